/* src/bbcw_pkg.sv */
`default_nettype none

package bbcw_pkg;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int RAD_W      = 3;
  localparam int NUM_CH     = 3;
  localparam int BIT_W      = $clog2(PIX_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 7;

  // register reset values
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 9'd256;
  localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  // request kinds
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVGO,
    ST_DIV
  } bbcw_state_t;

endpackage

`default_nettype wire

/* src/box_blur_clamped_window.sv */
// channel   ports                                          handshake
// input     in_action in_col in_row in_red_in in_green_in  start / busy
//           in_blue_in
// result    out_red_out out_green_out out_blue_out         out_valid (one-cycle strobe)
//           out_bad_coordinate
// config    cfg_index cfg_data                             cfg_valid / cfg_ready
//
// a load writes the store at accept, busy stays low and no result follows
// a request in the image runs from accept through setup, a scan of the N pixels of the
//   clipped window (N from 1 to 225 at radius 7) with one store read per cycle through
//   the single store port, then 8 shared subtract steps per channel, before its strobe
// a request outside the image gives its strobe from setup, with no store read or divide
// synchronous active-low reset clears control and loads the register defaults;
//   the pixel store is not cleared
// the receiver cannot stall: each result is shown once, for one cycle
`default_nettype none

module box_blur_clamped_window #(
  parameter int MAX_WIDTH  = bbcw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbcw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bbcw_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request side
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_action,
  input  wire logic [bbcw_pkg::COORD_W-1:0]    in_col,
  input  wire logic [bbcw_pkg::COORD_W-1:0]    in_row,
  input  wire logic [bbcw_pkg::PIX_W-1:0]      in_red_in,
  input  wire logic [bbcw_pkg::PIX_W-1:0]      in_green_in,
  input  wire logic [bbcw_pkg::PIX_W-1:0]      in_blue_in,
  // result side
  output logic                                 out_valid,
  output logic      [bbcw_pkg::PIX_W-1:0]      out_red_out,
  output logic      [bbcw_pkg::PIX_W-1:0]      out_green_out,
  output logic      [bbcw_pkg::PIX_W-1:0]      out_blue_out,
  output logic                                 out_bad_coordinate,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bbcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bbcw_pkg::*;

  // radius register is 3 bits, so the usable radius never exceeds its max code
  localparam int RAD_CODE_MAX = (1 << RAD_W) - 1;
  localparam int RAD_EFF_MAX  = (MAX_RADIUS < RAD_CODE_MAX) ? MAX_RADIUS : RAD_CODE_MAX;
  localparam int CNT_MAX      = (2 * RAD_EFF_MAX + 1) * (2 * RAD_EFF_MAX + 1);
  localparam int CNT_W        = $clog2(CNT_MAX + 1);
  localparam int SUM_W        = PIX_W + CNT_W;
  localparam int DEPTH        = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int RGB_W        = NUM_CH * PIX_W;

  bbcw_state_t state_r, state_nxt;

  // configuration registers
  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [RAD_W-1:0] window_radius_r;

  // effective (clamped) configuration
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [RAD_W-1:0] r_eff;

  logic accept;
  logic load_ok;
  logic bad_now;
  logic scan_issue;
  logic div_start;
  logic div_done;

  // request registers
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic               req_bad_r;

  // window bounds and scan position
  logic [DIM_W-1:0] r0, r1, c0, c1;
  logic [DIM_W-1:0] r0_r, r1_r, c0_r, c1_r;
  logic [DIM_W-1:0] i_r, j_r;
  logic [CNT_W-1:0] cnt_r;
  logic             rd_valid_r;

  logic [NUM_CH-1:0][SUM_W-1:0] sum_r;
  logic [NUM_CH-1:0][PIX_W-1:0] quot;

  // store port
  logic [DIM_W-1:0]  row_sel;
  logic [DIM_W-1:0]  col_sel;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [RGB_W-1:0]  ram_wdata;
  logic [RGB_W-1:0]  ram_rdata;

  // result registers
  logic             out_valid_r;
  logic [PIX_W-1:0] out_red_r;
  logic [PIX_W-1:0] out_green_r;
  logic [PIX_W-1:0] out_blue_r;
  logic             out_bad_r;

  // zero acts as one, anything past the store acts as the store size
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    if (image_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    if (32'(window_radius_r) > MAX_RADIUS) begin
      r_eff = RAD_W'(RAD_EFF_MAX);
    end else begin
      r_eff = window_radius_r;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign load_ok = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
  assign bad_now = ({1'b0, in_col} >= w_eff) || ({1'b0, in_row} >= h_eff);

  // clipped window bounds, worked out once per request
  always_comb begin
    logic [DIM_W-1:0] y9, x9, yr, xr, hm1, wm1;
    y9  = {1'b0, y_r};
    x9  = {1'b0, x_r};
    yr  = y9 + DIM_W'(r_eff);
    xr  = x9 + DIM_W'(r_eff);
    hm1 = h_eff - 1'b1;
    wm1 = w_eff - 1'b1;
    r0  = (y9 > DIM_W'(r_eff)) ? y9 - DIM_W'(r_eff) : '0;
    c0  = (x9 > DIM_W'(r_eff)) ? x9 - DIM_W'(r_eff) : '0;
    r1  = (yr < hm1) ? yr : hm1;
    c1  = (xr < wm1) ? xr : wm1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    scan_issue = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_action == ACT_REQUEST) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = req_bad_r ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        scan_issue = 1'b1;
        if (i_r == r1_r && j_r == c1_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last store read lands in the sums here
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // store port: loads write at accept, the scan reads one pixel a cycle
  assign row_sel   = (state_r == ST_SCAN) ? i_r : {1'b0, in_row};
  assign col_sel   = (state_r == ST_SCAN) ? j_r : {1'b0, in_col};
  assign ram_addr  = ADDR_W'(row_sel * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col_sel);
  assign ram_we    = accept && (in_action == ACT_LOAD) && load_ok;
  assign ram_wdata = {in_red_in, in_green_in, in_blue_in};

  bbcw_ram #(
    .WIDTH (RGB_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bbcw_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quot)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= RST_IMAGE_WIDTH;
      image_height_r  <= RST_IMAGE_HEIGHT;
      window_radius_r <= RST_WINDOW_RADIUS;
      rd_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:   image_width_r   <= cfg_data;
          REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data;
          REG_WINDOW_RADIUS: window_radius_r <= cfg_data[RAD_W-1:0];
          default: begin
            // unknown index, write dropped
          end
        endcase
      end
      rd_valid_r  <= scan_issue;
      out_valid_r <= ((state_r == ST_SETUP) && req_bad_r) ||
                     ((state_r == ST_DIV) && div_done);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_col;
      y_r       <= in_row;
      req_bad_r <= bad_now;
    end
    if (state_r == ST_SETUP) begin
      r0_r  <= r0;
      r1_r  <= r1;
      c0_r  <= c0;
      c1_r  <= c1;
      i_r   <= r0;
      j_r   <= c0;
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      if (scan_issue) begin
        cnt_r <= cnt_r + 1'b1;
        if (j_r == c1_r) begin
          j_r <= c0_r;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      // red sits in the top byte of a stored pixel
      if (rd_valid_r) begin
        for (int c = 0; c < NUM_CH; c++) begin
          sum_r[c] <= sum_r[c] + SUM_W'(ram_rdata[(NUM_CH - 1 - c) * PIX_W +: PIX_W]);
        end
      end
    end
    if ((state_r == ST_SETUP) && req_bad_r) begin
      out_red_r   <= '0;
      out_green_r <= '0;
      out_blue_r  <= '0;
      out_bad_r   <= 1'b1;
    end else if ((state_r == ST_DIV) && div_done) begin
      out_red_r   <= quot[0];
      out_green_r <= quot[1];
      out_blue_r  <= quot[2];
      out_bad_r   <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_out        = out_red_r;
  assign out_green_out      = out_green_r;
  assign out_blue_out       = out_blue_r;
  assign out_bad_coordinate = out_bad_r;

  // scan never leaves the clipped window
  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |->
      (i_r >= r0_r && i_r <= r1_r && j_r >= c0_r && j_r <= c1_r))
    else $error("scan position outside window");

  // divisor is a real pixel count when the divide starts
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVGO) |-> (cnt_r != '0 && 32'(cnt_r) <= CNT_MAX))
    else $error("window count out of range");

  // a request always moves on to setup
  a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_REQUEST) |=> (state_r == ST_SETUP))
    else $error("request not started");

  // a bad coordinate carries zero means
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_coordinate) |->
      (out_red_out == '0 && out_green_out == '0 && out_blue_out == '0))
    else $error("bad coordinate with nonzero means");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside divide phase");

endmodule

`default_nettype wire

/* src/bbcw_ram.sv */
`default_nettype none

module bbcw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* src/bbcw_div.sv */
`default_nettype none

module bbcw_div #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 8
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        start,
  input  wire logic [bbcw_pkg::NUM_CH-1:0][SUM_W-1:0]      dividend,
  input  wire logic [CNT_W-1:0]                            divisor,
  output logic                                             done,
  output logic      [bbcw_pkg::NUM_CH-1:0][bbcw_pkg::PIX_W-1:0] quotient
);

  import bbcw_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [1:0]       ch_r;
  logic [BIT_W-1:0] bit_r;
  logic [SUM_W-1:0] rem_r;
  logic [NUM_CH-1:0][PIX_W-1:0] q_r;

  logic [SUM_W-1:0] dsh;
  logic [SUM_W-1:0] diff;
  logic             ge;

  // quotient is known to fit in PIX_W bits, so only those trial subtracts run
  assign dsh  = SUM_W'(divisor) << bit_r;
  assign ge   = (rem_r >= dsh);
  assign diff = rem_r - dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ch_r   <= '0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ch_r   <= '0;
        bit_r  <= BIT_W'(PIX_W - 1);
      end else if (busy_r) begin
        if (bit_r == '0) begin
          bit_r <= BIT_W'(PIX_W - 1);
          if (ch_r == 2'(NUM_CH - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end else begin
          bit_r <= bit_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[0];
    end else if (busy_r) begin
      q_r[ch_r][bit_r] <= ge;
      if (bit_r == '0 && ch_r != 2'(NUM_CH - 1)) begin
        rem_r <= dividend[ch_r + 2'd1];
      end else if (ge) begin
        rem_r <= diff;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

/* dv/bbcw_blur_checker.sv */
`timescale 1ns / 100ps

module bbcw_blur_checker #(
  parameter int MAX_WIDTH  = bbcw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbcw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bbcw_pkg::DEF_MAX_RADIUS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            in_action,
  input  logic [bbcw_pkg::COORD_W-1:0]    in_col,
  input  logic [bbcw_pkg::COORD_W-1:0]    in_row,
  input  logic [bbcw_pkg::PIX_W-1:0]      in_red_in,
  input  logic [bbcw_pkg::PIX_W-1:0]      in_green_in,
  input  logic [bbcw_pkg::PIX_W-1:0]      in_blue_in,
  input  logic                            out_valid,
  input  logic [bbcw_pkg::PIX_W-1:0]      out_red_out,
  input  logic [bbcw_pkg::PIX_W-1:0]      out_green_out,
  input  logic [bbcw_pkg::PIX_W-1:0]      out_blue_out,
  input  logic                            out_bad_coordinate,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bbcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbcw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import bbcw_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             bad;
  } blur_t;

  // shadow of the loaded originals, red in the top byte
  bit   [NUM_CH*PIX_W-1:0] image_copy [STORE_DEPTH];
  logic [DIM_W-1:0]        width_q;
  logic [DIM_W-1:0]        height_q;
  logic [RAD_W-1:0]        radius_q;
  blur_t                   expected_blur [$];
  int                      errors;
  int                      result_num;

  function automatic int clip_dim(int raw, int limit);
    if (raw < 1) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic blur_t predict_blur(int x, int y);
    int w, h, rad, r0, r1, c0, c1, i, j, cnt;
    int sum_r, sum_g, sum_b;
    bit [NUM_CH*PIX_W-1:0] p;
    blur_t res;
    w   = clip_dim(int'(width_q), MAX_WIDTH);
    h   = clip_dim(int'(height_q), MAX_HEIGHT);
    rad = (int'(radius_q) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
    res = '0;
    if (x >= w || y >= h) begin
      res.bad = 1'b1;
      return res;
    end
    r0 = (y > rad) ? y - rad : 0;
    r1 = (y + rad < h - 1) ? y + rad : h - 1;
    c0 = (x > rad) ? x - rad : 0;
    c1 = (x + rad < w - 1) ? x + rad : w - 1;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt   = 0;
    for (i = r0; i <= r1; i++) begin
      for (j = c0; j <= c1; j++) begin
        p = image_copy[i * MAX_WIDTH + j];
        sum_r += int'(p[3*PIX_W-1:2*PIX_W]);
        sum_g += int'(p[2*PIX_W-1:PIX_W]);
        sum_b += int'(p[PIX_W-1:0]);
        cnt++;
      end
    end
    res.red   = PIX_W'(sum_r / cnt);
    res.green = PIX_W'(sum_g / cnt);
    res.blue  = PIX_W'(sum_b / cnt);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                             input logic [PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                result_num, name, got, want));
  endtask

  always @(posedge clk) begin
    blur_t got;
    blur_t want;
    if (!rst_n) begin
      width_q  = RST_IMAGE_WIDTH;
      height_q = RST_IMAGE_HEIGHT;
      radius_q = RST_WINDOW_RADIUS;
      expected_blur.delete();
      pending <= 0;
    end else begin
      if (out_valid) begin
        got.red   = out_red_out;
        got.green = out_green_out;
        got.blue  = out_blue_out;
        got.bad   = out_bad_coordinate;
        if (expected_blur.size() == 0) begin
          report_mismatch($sformatf("result %0d with no blur request outstanding",
                                    result_num));
        end else begin
          want = expected_blur.pop_front();
          check_field("red_out", got.red, want.red);
          check_field("green_out", got.green, want.green);
          check_field("blue_out", got.blue, want.blue);
          check_field("bad_coordinate", PIX_W'(got.bad), PIX_W'(want.bad));
        end
        result_num++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   width_q  = cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:  height_q = cfg_data[DIM_W-1:0];
          REG_WINDOW_RADIUS: radius_q = cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_action == ACT_LOAD) begin
          if (int'(in_col) < MAX_WIDTH && int'(in_row) < MAX_HEIGHT)
            image_copy[int'(in_row) * MAX_WIDTH + int'(in_col)] =
              {in_red_in, in_green_in, in_blue_in};
        end else begin
          expected_blur.push_back(predict_blur(int'(in_col), int'(in_row)));
        end
      end
      pending <= expected_blur.size();
    end
    fail_count <= errors;
  end

endmodule

/* dv/tb_box_blur_clamped_window.sv */
`timescale 1ns / 100ps

module tb_box_blur_clamped_window;
  import bbcw_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int MAX_H        = DEF_MAX_HEIGHT;
  localparam int MAX_R        = DEF_MAX_RADIUS;
  localparam int COORD_MAX    = 2 ** COORD_W - 1;
  localparam int ITEM_TARGET  = 1900;
  // covers the worst request of 225 reads plus the divide, and the long sender gaps
  localparam int CYCLE_LIMIT  = 3_000_000;
  // a load never raises busy, so a short settle is enough
  localparam int CFG_SETTLE   = 4;
  // longer than the slowest request, to catch stray strobes at the end
  localparam int DRAIN_CYCLES = 300;
  // index beyond the register list, writes to it must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_action;
  logic [COORD_W-1:0]    in_col;
  logic [COORD_W-1:0]    in_row;
  logic [PIX_W-1:0]      in_red_in;
  logic [PIX_W-1:0]      in_green_in;
  logic [PIX_W-1:0]      in_blue_in;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_red_out;
  logic [PIX_W-1:0]      out_green_out;
  logic [PIX_W-1:0]      out_blue_out;
  logic                  out_bad_coordinate;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // stimulus-side view of the live settings, already clipped to the legal range
  int eff_w;
  int eff_h;
  int eff_rad;
  int items_sent;
  int cycle_count;
  // when set, the current phase sends back to back with no gaps
  bit idle_burst;
  // pixels that have been loaded at least once, so windows never read garbage
  bit loaded [MAX_W*MAX_H];

  box_blur_clamped_window DUT (.*);

  bbcw_blur_checker u_blur_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs or a result never shows up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int eff_dim(int raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // mostly back to back or short holes, now and then a long pause
  function automatic int pick_gap();
    int roll;
    if (idle_burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pixel values lean toward the extremes so sums saturate and vanish
  function automatic logic [PIX_W-1:0] rand_pix();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  // random image sizes, mostly small, with zero and oversized values mixed in
  function automatic int rand_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return $urandom_range(1, 12);
    if (roll < 75) return 0;
    if (roll < 90) return $urandom_range(13, 256);
    return $urandom_range(257, 511);
  endfunction

  // place the loaded block at the low edge, the high edge or anywhere
  function automatic int pick_origin(int dim, int span);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return dim - span;
      default: return $urandom_range(0, dim - span);
    endcase
  endfunction

  // true when every pixel of the clipped window has been loaded, or the coordinate is outside the image
  function automatic bit window_ok(int col, int row);
    int r0, r1, c0, c1, i, j;
    if (col >= eff_w || row >= eff_h) return 1'b1;
    r0 = (row > eff_rad) ? row - eff_rad : 0;
    r1 = (row + eff_rad < eff_h - 1) ? row + eff_rad : eff_h - 1;
    c0 = (col > eff_rad) ? col - eff_rad : 0;
    c1 = (col + eff_rad < eff_w - 1) ? col + eff_rad : eff_w - 1;
    for (i = r0; i <= r1; i++) begin
      for (j = c0; j <= c1; j++) begin
        if (!loaded[i * MAX_W + j]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // one request on the input channel, held until start meets busy low
  task automatic send_item(input logic act, input int col, input int row,
                           input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                           input logic [PIX_W-1:0] blue);
    int gap;
    in_action   <= act;
    in_col      <= COORD_W'(col);
    in_row      <= COORD_W'(row);
    in_red_in   <= red;
    in_green_in <= green;
    in_blue_in  <= blue;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (act == ACT_LOAD && col < MAX_W && row < MAX_H) loaded[row * MAX_W + col] = 1'b1;
    // a zero gap leaves start high so the next request follows directly
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   eff_w   = eff_dim(value, MAX_W);
      REG_IMAGE_HEIGHT:  eff_h   = eff_dim(value, MAX_H);
      REG_WINDOW_RADIUS: eff_rad = ((value & 7) > MAX_R) ? MAX_R : (value & 7);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drop start, let every blur result come back, then allow a load to finish
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  // one setting of the registers: load a block of pixels, then mix blur requests
  // inside it, requests outside the image and further loads
  task automatic run_phase(input int wraw, input int hraw, input int rad);
    int  span_x, span_y, x0, y0, n_mix, col, row, tries, roll;
    bit  found;
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, wraw);
    write_reg(REG_IMAGE_HEIGHT, hraw);
    write_reg(REG_WINDOW_RADIUS, rad);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom_range(0, 511));
    idle_burst = ($urandom_range(0, 3) == 0);

    // block a bit wider than one window so both clipped and interior windows occur
    span_x = 2 * eff_rad + 1 + $urandom_range(0, 3);
    span_y = 2 * eff_rad + 1 + $urandom_range(0, 3);
    if (span_x > eff_w) span_x = eff_w;
    if (span_y > eff_h) span_y = eff_h;
    // tiny images are loaded whole
    if (eff_w * eff_h <= 64) begin
      span_x = eff_w;
      span_y = eff_h;
    end
    x0 = pick_origin(eff_w, span_x);
    y0 = pick_origin(eff_h, span_y);

    for (row = y0; row < y0 + span_y; row++) begin
      for (col = x0; col < x0 + span_x; col++) begin
        send_item(ACT_LOAD, col, row, rand_pix(), rand_pix(), rand_pix());
      end
    end

    n_mix = $urandom_range(60, 140);
    repeat (n_mix) begin
      roll  = $urandom_range(0, 99);
      found = 1'b0;
      if (roll < 55) begin
        // blur request whose whole window is already loaded
        for (tries = 0; tries < 8 && !found; tries++) begin
          col   = x0 + $urandom_range(0, span_x - 1);
          row   = y0 + $urandom_range(0, span_y - 1);
          found = window_ok(col, row);
        end
      end else if (roll < 65 && (eff_w < MAX_W || eff_h < MAX_H)) begin
        // coordinate outside the configured image
        found = 1'b1;
        if (eff_w < MAX_W && (eff_h == MAX_H || $urandom_range(0, 1) == 1)) begin
          col = $urandom_range(eff_w, COORD_MAX);
          row = $urandom_range(0, COORD_MAX);
        end else begin
          col = $urandom_range(0, COORD_MAX);
          row = $urandom_range(eff_h, COORD_MAX);
        end
      end
      if (found) begin
        // color inputs are don't-care for blur requests, drive noise
        send_item(ACT_REQUEST, col, row, PIX_W'($urandom), PIX_W'($urandom),
                  PIX_W'($urandom));
      end else if (roll >= 65 && roll < 72) begin
        // load anywhere in the store, possibly outside the image
        send_item(ACT_LOAD, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  rand_pix(), rand_pix(), rand_pix());
      end else begin
        // overwrite a pixel of the loaded block
        send_item(ACT_LOAD, x0 + $urandom_range(0, span_x - 1),
                  y0 + $urandom_range(0, span_y - 1), rand_pix(), rand_pix(), rand_pix());
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ACT_LOAD;
    in_col      = '0;
    in_row      = '0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_IMAGE_WIDTH;
    cfg_data    = '0;
    eff_w       = MAX_W;
    eff_h       = MAX_H;
    eff_rad     = MAX_R;
    items_sent  = 0;
    idle_burst  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x2 image, radius wider than the image so every window clips
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_WINDOW_RADIUS, 7);
    // unknown index with all data bits set, must leave the 2x2 setup alone
    write_reg(REG_UNUSED, 511);
    send_item(ACT_LOAD, 0, 0, 8'hff, 8'hff, 8'hff);
    send_item(ACT_LOAD, 1, 0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_LOAD, 0, 1, 8'h80, 8'h7f, 8'h01);
    send_item(ACT_LOAD, 1, 1, 8'hfe, 8'h01, 8'haa);
    // outside the image but inside the store: stored, no result
    send_item(ACT_LOAD, COORD_MAX, COORD_MAX, 8'h5a, 8'ha5, 8'h3c);
    send_item(ACT_REQUEST, 0, 0, '1, '1, '1);
    send_item(ACT_REQUEST, 1, 1, '0, '0, '0);
    // column, row and both past the image edge
    send_item(ACT_REQUEST, 2, 0, '0, '0, '0);
    send_item(ACT_REQUEST, 0, 2, '1, '1, '1);
    send_item(ACT_REQUEST, COORD_MAX, COORD_MAX, '0, '0, '0);
    // radius zero returns the pixel itself
    wait_idle();
    write_reg(REG_WINDOW_RADIUS, 0);
    send_item(ACT_REQUEST, 0, 0, '0, '0, '0);
    send_item(ACT_REQUEST, 1, 0, '1, '1, '1);
    send_item(ACT_REQUEST, 1, 1, '0, '0, '0);

    // register extremes: full store, zeros acting as one, oversized values,
    // single row and single column images
    run_phase(256, 256, 7);
    run_phase(0, 0, 0);
    run_phase(511, 511, 7);
    run_phase(1, 256, 3);
    run_phase(256, 1, 6);
    run_phase(257, 5, 1);
    run_phase(12, 0, 7);

    while (items_sent < ITEM_TARGET) run_phase(rand_dim(), rand_dim(), $urandom_range(0, 7));

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
